// ----- rtl/edd_pkg.sv -----
// Shared constants, types and tables for the RGB332 error-diffusion dither.
package edd_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Config register widths and reset values
    localparam int LW_W       = 9;
    localparam int FH_W       = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [LW_W-1:0] LW_RESET = LW_W'(256);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(212);

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Compare widths for the clamped dimensions
    localparam int WCMP_W = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
    localparam int HCMP_W = (ROW_W + 1 > FH_W) ? ROW_W + 1 : FH_W;

    // Row buffer is split into even and odd column banks
    localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;

    // Datapath widths
    localparam int CH_N  = 3;
    localparam int PIX_W = 8;
    localparam int ERR_W = 11;  // stored errors, sixteenths
    localparam int E_W   = 7;   // quantization error, -37..37
    localparam int V_W   = 10;  // adjusted value, -37..292
    localparam int S_W   = 14;  // pixel*16 plus accumulated error
    localparam int IDX_W = 3;

    localparam int S_TDATA_W = CH_N * PIX_W;
    localparam int M_TDATA_W = 8;

    // Channel order in the input beat
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Quantizer tables
    localparam int LEVEL_N    = 8;
    localparam int QUANT_SPAN = 19;
    localparam int LEVEL [LEVEL_N]    = '{0, 36, 73, 109, 146, 182, 219, 255};
    localparam int THRESH [LEVEL_N-1] = '{18, 54, 91, 127, 164, 200, 237};

    typedef logic [PIX_W-1:0]        pix_t;
    typedef logic signed [ERR_W-1:0] err_t;
    typedef err_t [CH_N-1:0]         err3_t;
    typedef logic [COL_W-1:0]        col_t;

    typedef struct packed {
        logic  en;
        col_t  col;
        err3_t data;
    } row_wr_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        err_t             err;        // e
        err_t             prev_sum;   // pending below-left + 3e
        err_t             below_sum;  // pending below + 5e
        err_t             right;      // 7e
    } chan_res_t;

endpackage

// ----- rtl/error_diffusion_dither_rgb332.sv -----
// Top level of the RGB332 error-diffusion dither (7/16, 3/16, 5/16, 1/16 weights).
//
// Takes one 24-bit RGB pixel per beat in raster order and returns one GGGRRRBB
// code per beat, with tlast on the last pixel of the frame. Throughput is one
// pixel per clock while m_tready is not held low; on accept the row buffer
// is read into the input stage, and as the pixel leaves the input stage the
// quantizer and error spread results are registered into the output register.
// The one-pixel rate is set by the error feedback in the diffusion stage: the
// right-hand error and the two pending below-row sums are registers updated
// by every pixel and used by the next. Errors are held exactly in signed
// sixteenths. The row buffer is two banks (even and odd columns) of
// MAX_WIDTH/2 x 33 bits so the two column writes at the end of a row land in
// the same cycle; per-column valid bits clear it at reset and at every frame end,
// so there is no clearing pass and the block accepts pixels right out of
// reset. A read of a column being written in the same cycle is forwarded.
// line_width and frame_height are written through the cfg port (index 0 and
// 1); zero acts as 1 and large values saturate to 256 x 1024. Write them only
// while the block is idle; the position counters keep running across a
// change and a position past the new last column or row counts as the last.
module error_diffusion_dither_rgb332 (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [edd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [edd_pkg::S_TDATA_W-1:0]      s_tdata,   // red_in, green_in, blue_in
    // code output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [edd_pkg::M_TDATA_W-1:0]      m_tdata,   // pixel_code
    output logic                               m_tlast    // frame_end
);
    import edd_pkg::*;

    // config
    logic [LW_W-1:0]  line_width_reg;
    logic [FH_W-1:0]  frame_height_reg;

    // position of the next pixel to be accepted
    col_t             col_reg;
    col_t             col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [WCMP_W-1:0] w_eff;
    logic [WCMP_W-1:0] col_inc;
    logic [HCMP_W-1:0] h_eff;
    logic [HCMP_W-1:0] row_inc;
    logic              last_col_now;
    logic              last_row_now;

    // input stage
    logic                   s1_valid_reg;
    pix_t [CH_N-1:0]        s1_pix_reg;
    col_t                   s1_col_reg;
    logic                   s1_last_col_reg;
    logic                   s1_last_row_reg;
    logic                   s1_fwd_en_reg;
    err3_t                  s1_fwd_data_reg;

    // diffusion state
    err3_t right_err_reg;
    err3_t pend0_reg;
    err3_t pend1_reg;
    err3_t right_err_next;
    err3_t pend0_next;
    err3_t pend1_next;

    // output register
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_code_reg;
    logic                  m_last_reg;

    logic       accept;
    logic       move;
    logic       below;
    err3_t      rd_data;
    err3_t      row_err;
    chan_res_t  res [CH_N];
    row_wr_t    wr_a;
    row_wr_t    wr_b;
    logic       clear;
    logic       hit_a;
    logic       hit_b;
    logic       fwd_en_next;
    err3_t      fwd_data_next;
    logic [M_TDATA_W-1:0] code_next;

    //------------------------------------------------------------------
    // Handshakes: the input stage advances whenever the output register
    // is free or being drained, so a beat can enter every cycle.
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign move      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || move;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LW_RESET;
            frame_height_reg <= FH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LINE_WIDTH: begin
                    line_width_reg <= cfg_data[LW_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_data[FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Frame position, tracked at the accept side so the row buffer read
    // address is known in the accept cycle.
    //------------------------------------------------------------------
    always_comb begin
        if (line_width_reg == '0) begin
            w_eff = WCMP_W'(1);
        end else if (WCMP_W'(line_width_reg) > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            w_eff = WCMP_W'(line_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = HCMP_W'(1);
        end else if (HCMP_W'(frame_height_reg) > HCMP_W'(MAX_HEIGHT)) begin
            h_eff = HCMP_W'(MAX_HEIGHT);
        end else begin
            h_eff = HCMP_W'(frame_height_reg);
        end

        col_inc      = WCMP_W'(col_reg) + WCMP_W'(1);
        row_inc      = HCMP_W'(row_reg) + HCMP_W'(1);
        last_col_now = (col_inc >= w_eff);
        last_row_now = (row_inc >= h_eff);

        if (last_col_now) begin
            col_next = '0;
            row_next = last_row_now ? '0 : row_inc[ROW_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    //------------------------------------------------------------------
    // Input stage
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s1_fwd_en_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg  <= 1'b1;
                s1_fwd_en_reg <= fwd_en_next;
            end else if (move) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg      <= s_tdata;
            s1_col_reg      <= col_reg;
            s1_last_col_reg <= last_col_now;
            s1_last_row_reg <= last_row_now;
            s1_fwd_data_reg <= fwd_data_next;
        end
    end

    edd_row_buf u_row_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_col  (col_reg),
        .rd_data (rd_data),
        .wr_a    (wr_a),
        .wr_b    (wr_b),
        .clear   (clear)
    );

    //------------------------------------------------------------------
    // Diffusion stage
    //------------------------------------------------------------------
    assign row_err = s1_fwd_en_reg ? s1_fwd_data_reg : rd_data;
    assign below   = !s1_last_row_reg;

    for (genvar c = 0; c < CH_N; c++) begin : g_chan
        edd_chan u_chan (
            .pix       (s1_pix_reg[c]),
            .row_err   (row_err[c]),
            .right_err (right_err_reg[c]),
            .pend0     (pend0_reg[c]),
            .pend1     (pend1_reg[c]),
            .res       (res[c])
        );
    end

    // Column x-1 is final once pixel x is done; at the row end column x
    // is final too. Last-row writes are zero.
    always_comb begin
        wr_a.en  = move && (s1_col_reg != '0);
        wr_a.col = s1_col_reg - col_t'(1);
        wr_b.en  = move && s1_last_col_reg;
        wr_b.col = s1_col_reg;
        for (int c = 0; c < CH_N; c++) begin
            wr_a.data[c]      = below ? res[c].prev_sum  : '0;
            wr_b.data[c]      = below ? res[c].below_sum : '0;
            right_err_next[c] = res[c].right;
            pend0_next[c]     = res[c].below_sum;
            pend1_next[c]     = res[c].err;
        end
        clear = move && s1_last_col_reg && s1_last_row_reg;

        // forward a same-cycle write (or a frame-end clear) to the read
        hit_a       = wr_a.en && (wr_a.col == col_reg);
        hit_b       = wr_b.en && (wr_b.col == col_reg);
        fwd_en_next = clear || hit_a || hit_b;
        if (hit_b) begin
            fwd_data_next = wr_b.data;
        end else if (hit_a) begin
            fwd_data_next = wr_a.data;
        end else begin
            fwd_data_next = '0;
        end

        code_next = {res[CH_GREEN].idx, res[CH_RED].idx,
                     res[CH_BLUE].idx[IDX_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_err_reg <= '0;
            pend0_reg     <= '0;
            pend1_reg     <= '0;
        end else if (move) begin
            if (s1_last_col_reg) begin
                right_err_reg <= '0;
                pend0_reg     <= '0;
                pend1_reg     <= '0;
            end else begin
                right_err_reg <= right_err_next;
                pend0_reg     <= pend0_next;
                pend1_reg     <= pend1_next;
            end
        end
    end

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_code_reg <= code_next;
            m_last_reg <= s1_last_col_reg && s1_last_row_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_code_reg;
    assign m_tlast  = m_last_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    // a frame-end pixel in the input stage means the position wrapped to 0,0
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_last_col_reg && s1_last_row_reg
        |-> (col_reg == '0) && (row_reg == '0))
        else $error("position did not wrap at frame end");

    // the two row-buffer writes of a cycle must go to different banks
    a_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_a.en && wr_b.en |-> (wr_a.col[0] != wr_b.col[0]))
        else $error("row buffer writes collide in one bank");

    // full input stage behind a stalled output must back-pressure
    a_backpress: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_tready |-> !s_tready)
        else $error("beat accepted while pipeline is full");

    // row end clears the carried errors
    a_row_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        move && s1_last_col_reg |=> (pend0_reg == '0) && (right_err_reg == '0))
        else $error("carried errors not cleared at row end");

endmodule

// ----- rtl/edd_chan.sv -----
// One color channel: error add, truncation, quantizer and error spread terms.
module edd_chan (
    input  edd_pkg::pix_t      pix,
    input  edd_pkg::err_t      row_err,
    input  edd_pkg::err_t      right_err,
    input  edd_pkg::err_t      pend0,
    input  edd_pkg::err_t      pend1,
    output edd_pkg::chan_res_t res
);
    import edd_pkg::*;

    logic signed [S_W-1:0] sum;
    logic [S_W-1:0]        trunc_bias;
    logic signed [S_W-1:0] sum_adj;
    logic signed [V_W-1:0] value;
    logic signed [V_W-1:0] lev;
    logic [IDX_W-1:0]      idx;
    logic signed [E_W-1:0] e_small;
    err_t                  e;

    // First threshold within span wins; very negative values go to level 0
    function automatic logic [IDX_W-1:0] quant_index(input logic signed [V_W-1:0] v);
        logic [IDX_W-1:0] q;
        logic             hit;
        q   = IDX_W'(LEVEL_N - 1);
        hit = 1'b0;
        for (int i = 0; i < LEVEL_N - 1; i++) begin
            if (!hit && (int'(v) >= THRESH[i] - QUANT_SPAN)
                     && (int'(v) <= THRESH[i] + QUANT_SPAN)) begin
                q   = IDX_W'(i);
                hit = 1'b1;
            end
        end
        if (int'(v) < -1) begin
            q = '0;
        end
        return q;
    endfunction

    always_comb begin
        sum = $signed({{(S_W-PIX_W-4){1'b0}}, pix, 4'b0000})
              + S_W'(row_err) + S_W'(right_err);
        // divide by 16 rounding toward zero
        trunc_bias = {{(S_W-4){1'b0}}, {4{sum[S_W-1]}}};
        sum_adj    = sum + $signed(trunc_bias);
        value      = V_W'(sum_adj >>> 4);
        idx        = quant_index(value);
        lev        = V_W'(LEVEL[idx]);
        e_small    = E_W'(value - lev);
        e          = ERR_W'(e_small);

        res.idx       = idx;
        res.err       = e;
        res.prev_sum  = pend0 + (e <<< 1) + e;
        res.below_sum = pend1 + (e <<< 2) + e;
        res.right     = (e <<< 3) - e;
    end

endmodule

// ----- rtl/edd_row_buf.sv -----
// Error row buffer: even/odd column banks with per-column valid bits.
module edd_row_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_en,
    input  edd_pkg::col_t   rd_col,
    output edd_pkg::err3_t  rd_data,
    input  edd_pkg::row_wr_t wr_a,
    input  edd_pkg::row_wr_t wr_b,
    input  logic            clear
);
    import edd_pkg::*;

    err3_t bank0_mem [BANK_DEPTH];
    err3_t bank1_mem [BANK_DEPTH];

    row_wr_t wr0;
    row_wr_t wr1;

    logic [MAX_WIDTH-1:0] valid_reg;
    logic [MAX_WIDTH-1:0] valid_next;
    err3_t                rd0_reg;
    err3_t                rd1_reg;
    logic                 rd_odd_reg;
    logic                 rd_vld_reg;

    // the two writes of a cycle are always on adjacent columns
    always_comb begin
        wr0 = '0;
        wr1 = '0;
        if (wr_a.en) begin
            if (wr_a.col[0]) begin
                wr1 = wr_a;
            end else begin
                wr0 = wr_a;
            end
        end
        if (wr_b.en) begin
            if (wr_b.col[0]) begin
                wr1 = wr_b;
            end else begin
                wr0 = wr_b;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr_a.en) begin
            valid_next[wr_a.col] = 1'b1;
        end
        if (wr_b.en) begin
            valid_next[wr_b.col] = 1'b1;
        end
        if (clear) begin
            valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr0.en) begin
            bank0_mem[wr0.col[COL_W-1:1]] <= wr0.data;
        end
        if (wr1.en) begin
            bank1_mem[wr1.col[COL_W-1:1]] <= wr1.data;
        end
        if (rd_en) begin
            rd0_reg    <= bank0_mem[rd_col[COL_W-1:1]];
            rd1_reg    <= bank1_mem[rd_col[COL_W-1:1]];
            rd_odd_reg <= rd_col[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_col];
            end
        end
    end

    assign rd_data = rd_vld_reg ? (rd_odd_reg ? rd1_reg : rd0_reg) : '0;

endmodule
